[rtl/mvts_pkg.sv]
package mvts_pkg;

   // Task table size
   localparam int MAX_TASKS = 16;
   localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int LIVE_W    = $clog2(MAX_TASKS + 1);
   localparam int CNT_W     = SLOT_W + 1;

   // Field widths
   localparam int ID_W    = 8;
   localparam int VR_W    = 32;
   localparam int LEN_W   = 16;
   localparam int TICK_W  = 32;
   localparam int KIND_W  = 2;
   localparam int COUNT_W = 5;

   localparam logic [VR_W-1:0] VR_MAX = '1;

   typedef enum logic {
      OP_ARRIVE = 1'b0,
      OP_TICK   = 1'b1
   } opcode_type;

   typedef enum logic [KIND_W-1:0] {
      REPLY_TICK   = 2'd0,
      REPLY_ACCEPT = 2'd1,
      REPLY_DROP   = 2'd2
   } reply_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ARRIVE,
      ST_TICK,
      ST_SCAN,
      ST_SCAN_END,
      ST_RD_RUN,
      ST_UPDATE,
      ST_OUT
   } state_type;

   // One task table entry
   typedef struct packed {
      logic [ID_W-1:0]  ident;
      logic [VR_W-1:0]  vruntime;
      logic [LEN_W-1:0] remaining;
   } slot_entry_type;

   // Control from the sequencer to the minimum search unit
   typedef struct packed {
      logic              clear;
      logic              valid;
      logic [SLOT_W-1:0] idx;
   } scan_ctl_type;

   // Result of the minimum search
   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] idx;
      logic [VR_W-1:0]   value;
   } scan_res_type;

endpackage

[rtl/mvts_ram.sv]
module mvts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(DEPTH)-1:0]       wr_addr,
   input  logic [WIDTH-1:0]               wr_data,
   input  logic [$clog2(DEPTH)-1:0]       rd_addr,
   output logic [WIDTH-1:0]               rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/mvts_minscan.sv]
module mvts_minscan (
   input  logic                               clock,
   input  logic                               reset,
   input  mvts_pkg::scan_ctl_type             ctl,
   input  logic [mvts_pkg::VR_W-1:0]          value,
   output mvts_pkg::scan_res_type             res
);

   logic                              found_ff, found_in;
   logic [mvts_pkg::SLOT_W-1:0]       idx_ff, idx_in;
   logic [mvts_pkg::VR_W-1:0]         value_ff, value_in;
   logic                              less;

   // Shared comparator: strict less keeps the lowest slot on a tie
   assign less = value < value_ff;

   always_comb begin
      found_in = found_ff;
      idx_in   = idx_ff;
      value_in = value_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (ctl.valid && (!found_ff || less)) begin
         found_in = 1'b1;
         idx_in   = ctl.idx;
         value_in = value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      idx_ff   <= idx_in;
      value_ff <= value_in;
   end

   assign res.found = found_ff;
   assign res.idx   = idx_ff;
   assign res.value = value_ff;

endmodule

[rtl/min_vruntime_task_scheduler.sv]
// Fair task scheduler with a minimum-virtual-runtime policy.
// Request channel (req_*): opcode 0 enters a task (task_id, task_length) into
// the lowest free slot of a 16-entry table; opcode 1 advances time by one tick.
// Response channel (rsp_*): exactly one response per request, in order.
// An arrival answers "accepted" or "dropped, table full" by way of the
// ARRIVE and OUT states. A tick with a task already running makes one pass
// of the minimum search over the table RAM; a tick that must first pick a
// task makes two passes. An idle tick (empty table) goes from the TICK
// state straight to the OUT state. The search is one comparator walking
// the table at one slot per cycle, fed by the RAM's registered read port;
// the block works on one request at a time and req_ready is high only
// while it waits for a new request.
// Results sit in an output register: a stalled receiver does not stop the
// block from taking the next request, but the following result waits until
// the held one is taken. Reset (synchronous) empties the table, clears the
// running task, the minimum runtime and the tick counter; table contents
// need no clearing since a slot's data is used only once it is marked valid.
module min_vruntime_task_scheduler (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_opcode,
   input  logic [mvts_pkg::ID_W-1:0]         req_task_id,
   input  logic [mvts_pkg::LEN_W-1:0]        req_task_length,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mvts_pkg::KIND_W-1:0]       rsp_reply_kind,
   output logic [mvts_pkg::TICK_W-1:0]       rsp_tick_number,
   output logic [mvts_pkg::COUNT_W-1:0]      rsp_runnable_count,
   output logic [mvts_pkg::ID_W-1:0]         rsp_ran_id,
   output logic                              rsp_idle_tick,
   output logic                              rsp_task_done
);

   mvts_pkg::state_type state_ff, state_in;

   // Control state
   logic [mvts_pkg::MAX_TASKS-1:0]  slot_valid_ff, slot_valid_in;
   logic [mvts_pkg::SLOT_W-1:0]     running_slot_ff, running_slot_in;
   logic                            running_valid_ff, running_valid_in;
   logic [mvts_pkg::VR_W-1:0]       floor_ff, floor_in;
   logic [mvts_pkg::TICK_W-1:0]     tick_ff, tick_in;
   logic [mvts_pkg::LIVE_W-1:0]     live_ff, live_in;
   logic [mvts_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic                            scan_vld_ff, scan_vld_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [mvts_pkg::ID_W-1:0]       id_ff, id_in;
   logic [mvts_pkg::LEN_W-1:0]      len_ff, len_in;
   logic [mvts_pkg::SLOT_W-1:0]     scan_idx_ff, scan_idx_in;
   logic [mvts_pkg::KIND_W-1:0]     pend_kind_ff, pend_kind_in;
   logic [mvts_pkg::TICK_W-1:0]     pend_tick_ff, pend_tick_in;
   logic [mvts_pkg::COUNT_W-1:0]    pend_count_ff, pend_count_in;
   logic [mvts_pkg::ID_W-1:0]       pend_id_ff, pend_id_in;
   logic                            pend_idle_ff, pend_idle_in;
   logic                            pend_done_ff, pend_done_in;
   logic [mvts_pkg::KIND_W-1:0]     rsp_kind_ff, rsp_kind_in;
   logic [mvts_pkg::TICK_W-1:0]     rsp_tick_ff, rsp_tick_in;
   logic [mvts_pkg::COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic [mvts_pkg::ID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic                            rsp_idle_ff, rsp_idle_in;
   logic                            rsp_done_ff, rsp_done_in;

   // Table RAM and search unit
   logic                            ram_we;
   logic [mvts_pkg::SLOT_W-1:0]     ram_waddr;
   mvts_pkg::slot_entry_type        ram_wdata;
   logic [mvts_pkg::SLOT_W-1:0]     ram_raddr;
   mvts_pkg::slot_entry_type        ram_rdata;
   mvts_pkg::scan_ctl_type          scan_ctl;
   mvts_pkg::scan_res_type          scan_res;

   // Free slot search and update helpers
   logic                            free_found;
   logic [mvts_pkg::SLOT_W-1:0]     free_idx;
   logic [mvts_pkg::SLOT_W-1:0]     cnt_slot;
   logic                            cnt_waiting;
   logic [mvts_pkg::VR_W-1:0]       vr_next;
   logic [mvts_pkg::LEN_W-1:0]      rem_next;
   logic                            req_fire;

   mvts_ram #(
      .WIDTH ($bits(mvts_pkg::slot_entry_type)),
      .DEPTH (mvts_pkg::MAX_TASKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   mvts_minscan u_minscan (
      .clock (clock),
      .reset (reset),
      .ctl   (scan_ctl),
      .value (ram_rdata.vruntime),
      .res   (scan_res)
   );

   assign req_ready = (state_ff == mvts_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // Lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = mvts_pkg::MAX_TASKS - 1; i >= 0; i--) begin
         if (!slot_valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = mvts_pkg::SLOT_W'(i);
         end
      end
   end

   // Slot being issued to the RAM during a search pass
   assign cnt_slot    = cnt_ff[mvts_pkg::SLOT_W-1:0];
   assign cnt_waiting = slot_valid_ff[cnt_slot]
                        && !(running_valid_ff && (running_slot_ff == cnt_slot));

   // Running task update
   assign vr_next  = (ram_rdata.vruntime == mvts_pkg::VR_MAX) ?
                     ram_rdata.vruntime : ram_rdata.vruntime + 1'b1;
   assign rem_next = (ram_rdata.remaining != '0) ?
                     ram_rdata.remaining - 1'b1 : ram_rdata.remaining;

   // Sequencer
   always_comb begin
      state_in         = state_ff;
      slot_valid_in    = slot_valid_ff;
      running_slot_in  = running_slot_ff;
      running_valid_in = running_valid_ff;
      floor_in         = floor_ff;
      tick_in          = tick_ff;
      live_in          = live_ff;
      cnt_in           = cnt_ff;
      scan_vld_in      = 1'b0;
      scan_idx_in      = cnt_slot;
      id_in            = id_ff;
      len_in           = len_ff;
      pend_kind_in     = pend_kind_ff;
      pend_tick_in     = pend_tick_ff;
      pend_count_in    = pend_count_ff;
      pend_id_in       = pend_id_ff;
      pend_idle_in     = pend_idle_ff;
      pend_done_in     = pend_done_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_kind_in      = rsp_kind_ff;
      rsp_tick_in      = rsp_tick_ff;
      rsp_count_in     = rsp_count_ff;
      rsp_id_in        = rsp_id_ff;
      rsp_idle_in      = rsp_idle_ff;
      rsp_done_in      = rsp_done_ff;
      ram_we           = 1'b0;
      ram_waddr        = free_idx;
      ram_wdata        = ram_rdata;
      ram_raddr        = cnt_slot;
      scan_ctl.clear   = 1'b0;
      scan_ctl.valid   = scan_vld_ff;
      scan_ctl.idx     = scan_idx_ff;

      case (state_ff)
         mvts_pkg::ST_IDLE: begin
            if (req_fire) begin
               id_in  = req_task_id;
               len_in = req_task_length;
               if (mvts_pkg::opcode_type'(req_opcode) == mvts_pkg::OP_TICK) begin
                  state_in = mvts_pkg::ST_TICK;
               end else begin
                  state_in = mvts_pkg::ST_ARRIVE;
               end
            end
         end

         // Arrival: store in lowest free slot or drop
         mvts_pkg::ST_ARRIVE: begin
            pend_tick_in = tick_ff;
            pend_id_in   = '0;
            pend_idle_in = 1'b0;
            pend_done_in = 1'b0;
            if (free_found) begin
               ram_we                   = 1'b1;
               ram_wdata.ident          = id_ff;
               ram_wdata.vruntime       = floor_ff;
               ram_wdata.remaining      = (len_ff == '0) ?
                                          mvts_pkg::LEN_W'(1) : len_ff;
               slot_valid_in[free_idx]  = 1'b1;
               live_in                  = live_ff + 1'b1;
               pend_kind_in             = mvts_pkg::REPLY_ACCEPT;
               pend_count_in            = mvts_pkg::COUNT_W'(live_ff + 1'b1);
            end else begin
               pend_kind_in  = mvts_pkg::REPLY_DROP;
               pend_count_in = mvts_pkg::COUNT_W'(live_ff);
            end
            state_in = mvts_pkg::ST_OUT;
         end

         // Tick: idle report or start a search pass
         mvts_pkg::ST_TICK: begin
            pend_kind_in = mvts_pkg::REPLY_TICK;
            pend_tick_in = tick_ff;
            pend_id_in   = '0;
            pend_done_in = 1'b0;
            if (live_ff == '0) begin
               pend_count_in = '0;
               pend_idle_in  = 1'b1;
               tick_in       = tick_ff + 1'b1;
               state_in      = mvts_pkg::ST_OUT;
            end else begin
               pend_count_in  = mvts_pkg::COUNT_W'(live_ff);
               pend_idle_in   = 1'b0;
               scan_ctl.clear = 1'b1;
               cnt_in         = '0;
               state_in       = mvts_pkg::ST_SCAN;
            end
         end

         // Walk the table one slot a cycle; the search sees each slot's data in the cycle after
         mvts_pkg::ST_SCAN: begin
            if (cnt_ff < mvts_pkg::CNT_W'(mvts_pkg::MAX_TASKS)) begin
               scan_vld_in = cnt_waiting;
               cnt_in      = cnt_ff + 1'b1;
            end else begin
               state_in = mvts_pkg::ST_SCAN_END;
            end
         end

         // With no task running the pass picks one; with one running it gives the minimum
         mvts_pkg::ST_SCAN_END: begin
            if (!running_valid_ff) begin
               running_slot_in  = scan_res.idx;
               running_valid_in = 1'b1;
               scan_ctl.clear   = 1'b1;
               cnt_in           = '0;
               state_in         = mvts_pkg::ST_SCAN;
            end else begin
               if (scan_res.found) begin
                  floor_in = scan_res.value;
               end
               state_in = mvts_pkg::ST_RD_RUN;
            end
         end

         mvts_pkg::ST_RD_RUN: begin
            ram_raddr = running_slot_ff;
            state_in  = mvts_pkg::ST_UPDATE;
         end

         // Charge one tick to the running task
         mvts_pkg::ST_UPDATE: begin
            ram_we              = 1'b1;
            ram_waddr           = running_slot_ff;
            ram_wdata.ident     = ram_rdata.ident;
            ram_wdata.vruntime  = vr_next;
            ram_wdata.remaining = rem_next;
            pend_id_in          = ram_rdata.ident;
            pend_done_in        = (rem_next == '0);
            if (rem_next == '0) begin
               slot_valid_in[running_slot_ff] = 1'b0;
               running_valid_in               = 1'b0;
               live_in                        = live_ff - 1'b1;
            end else if (vr_next > floor_ff) begin
               running_valid_in = 1'b0;
            end
            tick_in  = tick_ff + 1'b1;
            state_in = mvts_pkg::ST_OUT;
         end

         // Hand the result to the output register once it is free
         mvts_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = pend_kind_ff;
               rsp_tick_in  = pend_tick_ff;
               rsp_count_in = pend_count_ff;
               rsp_id_in    = pend_id_ff;
               rsp_idle_in  = pend_idle_ff;
               rsp_done_in  = pend_done_ff;
               state_in     = mvts_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = mvts_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mvts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff    <= '0;
         running_slot_ff  <= '0;
         running_valid_ff <= 1'b0;
         floor_ff         <= '0;
         tick_ff          <= '0;
         live_ff          <= '0;
         cnt_ff           <= '0;
         scan_vld_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         slot_valid_ff    <= slot_valid_in;
         running_slot_ff  <= running_slot_in;
         running_valid_ff <= running_valid_in;
         floor_ff         <= floor_in;
         tick_ff          <= tick_in;
         live_ff          <= live_in;
         cnt_ff           <= cnt_in;
         scan_vld_ff      <= scan_vld_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      id_ff         <= id_in;
      len_ff        <= len_in;
      scan_idx_ff   <= scan_idx_in;
      pend_kind_ff  <= pend_kind_in;
      pend_tick_ff  <= pend_tick_in;
      pend_count_ff <= pend_count_in;
      pend_id_ff    <= pend_id_in;
      pend_idle_ff  <= pend_idle_in;
      pend_done_ff  <= pend_done_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_tick_ff   <= rsp_tick_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_idle_ff   <= rsp_idle_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_reply_kind     = rsp_kind_ff;
   assign rsp_tick_number    = rsp_tick_ff;
   assign rsp_runnable_count = rsp_count_ff;
   assign rsp_ran_id         = rsp_id_ff;
   assign rsp_idle_tick      = rsp_idle_ff;
   assign rsp_task_done      = rsp_done_ff;

   // Live count tracks the valid slots
   a_live_matches_valid: assert property (
      @(posedge clock) disable iff (reset)
      $countones(slot_valid_ff) == live_ff
   ) else $error("live count disagrees with valid slots");

   // The running task always occupies a valid slot
   a_running_is_valid: assert property (
      @(posedge clock) disable iff (reset)
      running_valid_ff |-> slot_valid_ff[running_slot_ff]
   ) else $error("running task points at an empty slot");

   // A search pass that picks a task must find one
   a_pick_found: assert property (
      @(posedge clock) disable iff (reset)
      (state_ff == mvts_pkg::ST_SCAN_END && !running_valid_ff) |-> scan_res.found
   ) else $error("no waiting task found while tasks are live");

   // A taken request leaves the idle state on the next cycle
   a_req_starts_work: assert property (
      @(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == mvts_pkg::ST_ARRIVE || state_ff == mvts_pkg::ST_TICK)
   ) else $error("request taken but no work started");

endmodule
